### rtl/swm_pkg.sv
// Package for the sliding window mean unit: sizes, widths and reset values.
// Used by the channel interfaces, the divider and the top-level unit.
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;

  // Sample store depth; the ring addressing assumes a power of two.
  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int LEN_BITS   = 7;
  localparam int ADDR_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS   = SAMPLE_BITS + ADDR_BITS;
  localparam int MEAN_BITS  = SAMPLE_BITS + FRAC_BITS;
  localparam int DIVD_BITS  = SUM_BITS + FRAC_BITS;
  localparam int STEP_BITS  = $clog2(DIVD_BITS);

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MEAN_BITS-1:0]   mean_t;
  typedef logic        [LEN_BITS-1:0]    len_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [CNT_BITS-1:0]    cnt_t;
  typedef logic        [ADDR_BITS-1:0]   addr_t;
  typedef logic        [DIVD_BITS-1:0]   divd_t;

endpackage
`default_nettype wire

### rtl/swm_if.sv
// Valid/ready channel interfaces for samples, means and the length register.
// Depends on swm_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface swm_sample_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_mean_if;
  import swm_pkg::*;
  logic  valid;
  logic  ready;
  mean_t mean_q8;
  modport source (output valid, output mean_q8, input ready);
  modport sink (input valid, input mean_q8, output ready);
endinterface

interface swm_cfg_if;
  import swm_pkg::*;
  logic valid;
  logic ready;
  len_t window_length;
  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface
`default_nettype wire

### rtl/swm_sample_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module swm_sample_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/swm_divider.sv
// Restoring divider, one quotient bit per cycle, for the mean computation.
// Depends on swm_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps
`default_nettype none
module swm_divider (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire swm_pkg::divd_t dividend,
  input  wire swm_pkg::cnt_t  divisor,
  output logic               done,
  output swm_pkg::divd_t     quotient
);
  import swm_pkg::*;

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  cnt_t                 divisor_r;
  cnt_t                 rem;
  logic [CNT_BITS:0]    shifted;
  logic [CNT_BITS:0]    diff;
  logic                 fits;

  // The remainder stays below the divisor, so it fits the count width.
  assign shifted = {rem, quotient[DIVD_BITS-1]};
  assign diff    = shifted - {1'b0, divisor_r};
  assign fits    = shifted >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= STEP_BITS'(DIVD_BITS - 1);
        quotient  <= dividend;
        divisor_r <= divisor;
        rem       <= '0;
      end else if (busy) begin
        rem      <= fits ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
        quotient <= {quotient[DIVD_BITS-2:0], fits};
        step     <= step - STEP_BITS'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/sliding_window_mean_unit.sv
// Sliding window mean unit: moving average of signed samples, Q8 result.
// Path from sample beat to mean beat: store read, update, bit-serial divide, load into the output register.
// A new sample is taken only once the mean of the last one is in the output register.
// Reset (rst, synchronous): window empty, write slot 0, window length 3, no mean pending.
// Depends on swm_pkg, swm_if, swm_sample_ram and swm_divider.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_mean_unit (
  input wire logic  clk,
  input wire logic  rst,
  swm_sample_if.sink samples,
  swm_mean_if.source means,
  swm_cfg_if.sink    cfg
);
  import swm_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    UPDATE,
    DIVIDE,
    DRAIN
  } state_t;

  state_t  state;
  len_t    window_length;
  addr_t   write_slot;
  cnt_t    fill_count;
  sum_t    running_sum;
  sample_t sample_r;
  logic    evict;
  logic    neg;
  logic    out_valid;
  mean_t   out_mean;

  cnt_t    len_eff;
  addr_t   oldest;
  sample_t old_sample;
  sum_t    running_sum_next;
  cnt_t    fill_count_next;
  sum_t    mag;
  divd_t   dividend;
  logic    div_start;
  logic    div_done;
  divd_t   quotient;
  mean_t   q_trunc;
  logic    out_free;
  logic    out_load;
  logic    sample_beat;

  // The block takes samples and length writes only between items. A length
  // write offered in the same cycle as a sample goes first; the sample waits.
  assign samples.ready = (state == IDLE) && !cfg.valid;
  assign cfg.ready     = (state == IDLE);
  assign sample_beat   = samples.valid && samples.ready;

  assign means.valid   = out_valid;
  assign means.mean_q8 = out_mean;
  assign out_free      = !out_valid || means.ready;

  // A finished quotient moves into the output register once it is free.
  assign out_load = out_free && (((state == DIVIDE) && div_done) || (state == DRAIN));

  // A length of zero acts as one, and a length above the store depth is clamped.
  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_BITS'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      len_eff = CNT_BITS'(WINDOW_MAX);
    end else begin
      len_eff = CNT_BITS'(window_length);
    end
  end

  // The oldest held sample sits fill_count entries behind the write slot.
  // With a full store this wraps onto the write slot itself.
  assign oldest = write_slot - fill_count[ADDR_BITS-1:0];

  swm_sample_ram #(
    .DEPTH(WINDOW_MAX),
    .WIDTH(SAMPLE_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (state == UPDATE),
    .waddr(write_slot),
    .wdata(sample_r),
    .raddr(oldest),
    .rdata(old_sample)
  );

  // In the update cycle the evicted sample, read on the accepting edge, is
  // already on the read port; it leaves the sum and the new sample enters.
  always_comb begin
    running_sum_next = running_sum + SUM_BITS'(sample_r);
    if (evict) begin
      running_sum_next = running_sum_next - SUM_BITS'(old_sample);
    end
    fill_count_next = evict ? fill_count : fill_count + CNT_BITS'(1);
    mag      = running_sum_next[SUM_BITS-1] ? -running_sum_next : running_sum_next;
    dividend = {mag, FRAC_BITS'(0)};
  end

  assign div_start = (state == UPDATE);

  swm_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (fill_count_next),
    .done    (div_done),
    .quotient(quotient)
  );

  // The mean is within the result range, so the low bits of the quotient carry it.
  assign q_trunc = mean_t'(quotient[MEAN_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      window_length <= LEN_RESET;
      write_slot    <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
      out_valid     <= 1'b0;
    end else begin
      // The output holds its beat until taken, or takes a new one.
      out_valid <= out_load || (out_valid && !means.ready);
      case (state)
        IDLE: begin
          if (cfg.valid) begin
            // A new length empties the window.
            window_length <= cfg.window_length;
            write_slot    <= '0;
            fill_count    <= '0;
            running_sum   <= '0;
          end else if (sample_beat) begin
            sample_r <= samples.sample;
            evict    <= (fill_count >= len_eff) && (fill_count != '0);
            state    <= UPDATE;
          end
        end
        UPDATE: begin
          running_sum <= running_sum_next;
          fill_count  <= fill_count_next;
          write_slot  <= write_slot + ADDR_BITS'(1);
          neg         <= running_sum_next[SUM_BITS-1];
          state       <= DIVIDE;
        end
        DIVIDE: begin
          if (div_done) begin
            if (out_free) begin
              out_mean <= neg ? -q_trunc : q_trunc;
              state    <= IDLE;
            end else begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          // The divider holds its quotient until the next start.
          if (out_free) begin
            out_mean <= neg ? -q_trunc : q_trunc;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
